>>> src/fmm_pkg.sv
package fmm_pkg;

    localparam logic [1:0] KIND_LOAD_A = 2'd0;
    localparam logic [1:0] KIND_LOAD_B = 2'd1;
    localparam logic [1:0] KIND_REQ    = 2'd2;

    localparam logic [1:0] CFG_ROWS_M  = 2'd0;
    localparam logic [1:0] CFG_INNER_N = 2'd1;
    localparam logic [1:0] CFG_COLS_P  = 2'd2;

    typedef enum logic [1:0] {
        OP_LOAD_A  = 2'd0,
        OP_LOAD_B  = 2'd1,
        OP_REQ     = 2'd2,
        OP_REQ_OOR = 2'd3
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [5:0]  row;
        logic [5:0]  col;
        logic [31:0] value;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

endpackage

>>> src/float_matrix_multiply_core.sv
// Channel   Direction  Signals
// request   in         in_valid, in_stall, kind, row, col, value_bits
// result    out        out_valid, out_stall, product_bits, out_of_range
// config    in         cfg_valid, cfg_ready, cfg_index, cfg_data
//
// A load is written into its store as the back end pops it; a request in range passes,
// once per inner step, through the shared read, multiply, round, align and add stages.
// A request out of range or with inner_n of zero goes straight to the output stage.
// Reset clears the configuration to 64 and empties the queue; the stores hold no reset.
// A two-entry queue lets the front accept requests while the back end is busy or its
// result register is stalled.
module float_matrix_multiply_core #(
    parameter int MAX_DIM = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  kind,
    input  logic [5:0]  row,
    input  logic [5:0]  col,
    input  logic [31:0] value_bits,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] product_bits,
    output logic        out_of_range,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [6:0]  cfg_data
);

    localparam int SW = ($clog2(MAX_DIM + 1) > 7) ? $clog2(MAX_DIM + 1) : 7;

    fmm_pkg::qstat_t qstat;
    fmm_pkg::cmd_t   push_cmd;
    fmm_pkg::cmd_t   pop_cmd;
    logic            q_push;
    logic            q_pop;
    logic [SW-1:0]   inner_eff;

    fmm_front #(
        .MAX_DIM(MAX_DIM),
        .SW(SW)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .kind(kind),
        .row(row),
        .col(col),
        .value_bits(value_bits),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .qstat(qstat),
        .q_push(q_push),
        .q_cmd(push_cmd),
        .inner_eff(inner_eff)
    );

    fmm_queue u_queue (
        .clk(clk),
        .rst_n(rst_n),
        .push(q_push),
        .push_cmd(push_cmd),
        .pop(q_pop),
        .pop_cmd(pop_cmd),
        .qstat(qstat)
    );

    fmm_back #(
        .MAX_DIM(MAX_DIM),
        .SW(SW)
    ) u_back (
        .clk(clk),
        .rst_n(rst_n),
        .qstat(qstat),
        .pop_cmd(pop_cmd),
        .q_pop(q_pop),
        .inner_eff(inner_eff),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .product_bits(product_bits),
        .out_of_range(out_of_range)
    );

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !qstat.full)
        else $error("push into a full queue");
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> !qstat.empty)
        else $error("pop from an empty queue");
    assert property (@(posedge clk) disable iff (!rst_n)
                     (out_valid && out_of_range) |-> (product_bits == 32'd0))
        else $error("out-of-range request with a non-zero result");
`endif

endmodule

>>> src/fmm_front.sv
module fmm_front #(
    parameter int MAX_DIM = 64,
    parameter int SW      = 7
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          kind,
    input  logic [5:0]          row,
    input  logic [5:0]          col,
    input  logic [31:0]         value_bits,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [6:0]          cfg_data,
    input  fmm_pkg::qstat_t     qstat,
    output logic                q_push,
    output fmm_pkg::cmd_t       q_cmd,
    output logic [SW-1:0]       inner_eff
);

    logic [6:0]    rows_reg;
    logic [6:0]    inner_reg;
    logic [6:0]    cols_reg;
    logic [SW-1:0] m_eff;
    logic [SW-1:0] p_eff;
    logic [SW-1:0] row_x;
    logic [SW-1:0] col_x;
    logic          keep;

    assign cfg_ready = 1'b1;
    assign in_stall  = qstat.full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg  <= 7'd64;
            inner_reg <= 7'd64;
            cols_reg  <= 7'd64;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                fmm_pkg::CFG_ROWS_M:  rows_reg  <= cfg_data;
                fmm_pkg::CFG_INNER_N: inner_reg <= cfg_data;
                fmm_pkg::CFG_COLS_P:  cols_reg  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign m_eff = (SW'(rows_reg) > SW'(MAX_DIM)) ? SW'(MAX_DIM) : SW'(rows_reg);
    assign inner_eff = (SW'(inner_reg) > SW'(MAX_DIM)) ? SW'(MAX_DIM) : SW'(inner_reg);
    assign p_eff = (SW'(cols_reg) > SW'(MAX_DIM)) ? SW'(MAX_DIM) : SW'(cols_reg);
    assign row_x = SW'(row);
    assign col_x = SW'(col);

    always_comb
    begin
        q_cmd.row   = row;
        q_cmd.col   = col;
        q_cmd.value = value_bits;
        q_cmd.op    = fmm_pkg::OP_REQ;
        keep        = 1'b0;
        unique case (kind)
            fmm_pkg::KIND_LOAD_A:
            begin
                q_cmd.op = fmm_pkg::OP_LOAD_A;
                keep     = (row_x < m_eff) && (col_x < inner_eff);
            end
            fmm_pkg::KIND_LOAD_B:
            begin
                q_cmd.op = fmm_pkg::OP_LOAD_B;
                keep     = (row_x < inner_eff) && (col_x < p_eff);
            end
            fmm_pkg::KIND_REQ:
            begin
                keep     = 1'b1;
                q_cmd.op = ((row_x >= m_eff) || (col_x >= p_eff)) ? fmm_pkg::OP_REQ_OOR
                                                                  : fmm_pkg::OP_REQ;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign q_push = in_valid && !qstat.full && keep;

endmodule

>>> src/fmm_queue.sv
module fmm_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  fmm_pkg::cmd_t   push_cmd,
    input  logic            pop,
    output fmm_pkg::cmd_t   pop_cmd,
    output fmm_pkg::qstat_t qstat
);

    fmm_pkg::cmd_t q_mem [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    count_reg;
    logic [1:0]    count_next;

    assign pop_cmd     = q_mem[rd_ptr_reg];
    assign qstat.full  = (count_reg == 2'd2);
    assign qstat.empty = (count_reg == 2'd0);

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

endmodule

>>> src/fmm_back.sv
module fmm_back #(
    parameter int MAX_DIM = 64,
    parameter int SW      = 7
) (
    input  logic            clk,
    input  logic            rst_n,
    input  fmm_pkg::qstat_t qstat,
    input  fmm_pkg::cmd_t   pop_cmd,
    output logic            q_pop,
    input  logic [SW-1:0]   inner_eff,
    output logic            out_valid,
    input  logic            out_stall,
    output logic [31:0]     product_bits,
    output logic            out_of_range
);

    localparam int AW        = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int MEM_DEPTH = 1 << (2 * AW);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_RD   = 7'b0000010,
        S_MUL  = 7'b0000100,
        S_MRND = 7'b0001000,
        S_ADD1 = 7'b0010000,
        S_ADD2 = 7'b0100000,
        S_OUT  = 7'b1000000
    } state_t;

    localparam logic [31:0] QNAN = 32'hFFC00000;

    function automatic logic [5:0] lzc51(input logic [50:0] v);
        logic [5:0] n;
        n = 6'd51;
        for (int i = 0; i < 51; i++)
        begin
            if (v[i])
            begin
                n = 6'(50 - i);
            end
        end
        return n;
    endfunction

    function automatic logic [31:0] round_pack(input logic sign, input logic signed [11:0] re,
                                               input logic [49:0] sig);
        logic [11:0] sh;
        logic [49:0] s;
        logic        st;
        logic [11:0] rexp;
        logic [23:0] mant;
        logic        rnd;
        logic [35:0] tot;
        if (re < 12'sd1)
        begin
            sh   = 12'(12'sd1 - re);
            rexp = 12'd1;
            if (sh > 12'd49)
            begin
                s  = '0;
                st = |sig;
            end
            else
            begin
                s  = sig >> sh;
                st = |(sig & ~({50{1'b1}} << sh));
            end
        end
        else
        begin
            s    = sig;
            st   = 1'b0;
            rexp = 12'(re);
        end
        mant = s[49:26];
        rnd  = s[25] & (st | (|s[24:0]) | mant[0]);
        tot  = {1'b0, 12'(rexp - 12'd1), 23'b0} + 36'(mant) + 36'(rnd);
        if (tot[34:23] >= 12'd255)
        begin
            return {sign, 8'hFF, 23'b0};
        end
        return {sign, tot[30:0]};
    endfunction

    state_t          state_reg;
    state_t          state_next;
    logic [AW-1:0]   r_reg;
    logic [AW-1:0]   c_reg;
    logic [SW-1:0]   k_reg;
    logic [31:0]     sum_reg;
    logic            oor_reg;
    logic [31:0]     prod_reg;
    logic [31:0]     a_mem [MEM_DEPTH];
    logic [31:0]     b_mem [MEM_DEPTH];
    logic [31:0]     a_rd_reg;
    logic [31:0]     b_rd_reg;
    logic [47:0]     mp_reg;
    logic [9:0]      mexp_reg;
    logic            msign_reg;
    logic            mspec_reg;
    logic [31:0]     mspec_bits_reg;
    logic [50:0]     as_reg;
    logic [7:0]      aexp_reg;
    logic            asign_reg;
    logic            azsign_reg;
    logic            aspec_reg;
    logic [31:0]     aspec_bits_reg;
    logic            out_valid_reg;
    logic [31:0]     out_bits_reg;
    logic            out_oor_reg;
    logic            out_free;
    logic [SW-1:0]   ld_row;
    logic [SW-1:0]   ld_col;
    logic [2*AW-1:0] wr_addr;
    logic            we_a;
    logic            we_b;

    logic            m_spec;
    logic [31:0]     m_spec_bits;
    logic [47:0]     m_prod;
    logic [9:0]      m_exp;
    logic [5:0]      mr_lz;
    logic [50:0]     mr_norm;
    logic [31:0]     mr_bits;

    logic            a_spec;
    logic [31:0]     a_spec_bits;
    logic [31:0]     a_big;
    logic [31:0]     a_sml;
    logic [7:0]      a_ebig;
    logic [7:0]      a_esml;
    logic [7:0]      a_d;
    logic [49:0]     a_bfull;
    logic [49:0]     a_bsh;
    logic            a_st;
    logic [50:0]     a_sum;
    logic [5:0]      ar_lz;
    logic [50:0]     ar_norm;
    logic [31:0]     ar_bits;

    assign out_free     = !out_valid_reg || !out_stall;
    assign out_valid    = out_valid_reg;
    assign product_bits = out_bits_reg;
    assign out_of_range = out_oor_reg;

    assign q_pop   = (state_reg == S_IDLE) && !qstat.empty;
    assign ld_row  = SW'(pop_cmd.row);
    assign ld_col  = SW'(pop_cmd.col);
    assign wr_addr = {ld_row[AW-1:0], ld_col[AW-1:0]};
    assign we_a    = q_pop && (pop_cmd.op == fmm_pkg::OP_LOAD_A);
    assign we_b    = q_pop && (pop_cmd.op == fmm_pkg::OP_LOAD_B);

    always_ff @(posedge clk)
    begin
        if (we_a)
        begin
            a_mem[wr_addr] <= pop_cmd.value;
        end
        if (we_b)
        begin
            b_mem[wr_addr] <= pop_cmd.value;
        end
        a_rd_reg <= a_mem[{r_reg, k_reg[AW-1:0]}];
        b_rd_reg <= b_mem[{k_reg[AW-1:0], c_reg}];
    end

    always_comb
    begin
        m_spec      = 1'b1;
        m_spec_bits = {a_rd_reg[31] ^ b_rd_reg[31], 31'b0};
        if ((a_rd_reg[30:23] == 8'hFF) && (a_rd_reg[22:0] != '0))
        begin
            m_spec_bits = a_rd_reg | 32'h00400000;
        end
        else if ((b_rd_reg[30:23] == 8'hFF) && (b_rd_reg[22:0] != '0))
        begin
            m_spec_bits = b_rd_reg | 32'h00400000;
        end
        else if (((a_rd_reg[30:23] == 8'hFF) && (b_rd_reg[30:0] == '0)) ||
                 ((b_rd_reg[30:23] == 8'hFF) && (a_rd_reg[30:0] == '0)))
        begin
            m_spec_bits = QNAN;
        end
        else if ((a_rd_reg[30:23] == 8'hFF) || (b_rd_reg[30:23] == 8'hFF))
        begin
            m_spec_bits = {a_rd_reg[31] ^ b_rd_reg[31], 8'hFF, 23'b0};
        end
        else if (!((a_rd_reg[30:0] == '0) || (b_rd_reg[30:0] == '0)))
        begin
            m_spec = 1'b0;
        end
        m_prod = {a_rd_reg[30:23] != 8'd0, a_rd_reg[22:0]}
               * {b_rd_reg[30:23] != 8'd0, b_rd_reg[22:0]};
        m_exp  = 10'((a_rd_reg[30:23] == 8'd0) ? 8'd1 : a_rd_reg[30:23])
               + 10'((b_rd_reg[30:23] == 8'd0) ? 8'd1 : b_rd_reg[30:23]);
    end

    always_comb
    begin
        mr_lz   = lzc51({mp_reg, 3'b0});
        mr_norm = {mp_reg, 3'b0} << mr_lz;
        mr_bits = round_pack(msign_reg,
                             12'($signed({2'b0, mexp_reg}) - 12'sd126 - $signed({6'b0, mr_lz})),
                             {mr_norm[50:2], |mr_norm[1:0]});
    end

    always_comb
    begin
        a_spec      = 1'b1;
        a_spec_bits = sum_reg;
        if ((sum_reg[30:23] == 8'hFF) && (sum_reg[22:0] != '0))
        begin
            a_spec_bits = sum_reg | 32'h00400000;
        end
        else if ((prod_reg[30:23] == 8'hFF) && (prod_reg[22:0] != '0))
        begin
            a_spec_bits = prod_reg | 32'h00400000;
        end
        else if ((sum_reg[30:23] == 8'hFF) && (prod_reg[30:23] == 8'hFF) &&
                 (sum_reg[31] != prod_reg[31]))
        begin
            a_spec_bits = QNAN;
        end
        else if (sum_reg[30:23] == 8'hFF)
        begin
            a_spec_bits = sum_reg;
        end
        else if (prod_reg[30:23] == 8'hFF)
        begin
            a_spec_bits = prod_reg;
        end
        else
        begin
            a_spec = 1'b0;
        end
        if (sum_reg[30:0] >= prod_reg[30:0])
        begin
            a_big = sum_reg;
            a_sml = prod_reg;
        end
        else
        begin
            a_big = prod_reg;
            a_sml = sum_reg;
        end
        a_ebig  = (a_big[30:23] == 8'd0) ? 8'd1 : a_big[30:23];
        a_esml  = (a_sml[30:23] == 8'd0) ? 8'd1 : a_sml[30:23];
        a_d     = a_ebig - a_esml;
        a_bfull = {a_sml[30:23] != 8'd0, a_sml[22:0], 26'b0};
        if (a_d > 8'd49)
        begin
            a_bsh = '0;
            a_st  = |a_bfull;
        end
        else
        begin
            a_bsh = a_bfull >> a_d;
            a_st  = |(a_bfull & ~({50{1'b1}} << a_d));
        end
        a_bsh[0] = a_bsh[0] | a_st;
        if (a_big[31] == a_sml[31])
        begin
            a_sum = {1'b0, a_big[30:23] != 8'd0, a_big[22:0], 26'b0} + {1'b0, a_bsh};
        end
        else
        begin
            a_sum = {1'b0, a_big[30:23] != 8'd0, a_big[22:0], 26'b0} - {1'b0, a_bsh};
        end
    end

    always_comb
    begin
        ar_lz   = lzc51(as_reg);
        ar_norm = as_reg << ar_lz;
        ar_bits = round_pack(asign_reg,
                             12'($signed({4'b0, aexp_reg}) + 12'sd1 - $signed({6'b0, ar_lz})),
                             {ar_norm[50:2], |ar_norm[1:0]});
        if (aspec_reg)
        begin
            ar_bits = aspec_bits_reg;
        end
        else if (as_reg == '0)
        begin
            ar_bits = {azsign_reg, 31'b0};
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (q_pop)
                begin
                    if (pop_cmd.op == fmm_pkg::OP_REQ_OOR)
                    begin
                        state_next = S_OUT;
                    end
                    else if (pop_cmd.op == fmm_pkg::OP_REQ)
                    begin
                        state_next = (inner_eff == '0) ? S_OUT : S_RD;
                    end
                end
            end
            S_RD:   state_next = S_MUL;
            S_MUL:  state_next = S_MRND;
            S_MRND: state_next = S_ADD1;
            S_ADD1: state_next = S_ADD2;
            S_ADD2: state_next = (SW'(k_reg + 1'b1) == inner_eff) ? S_OUT : S_RD;
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == S_OUT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            r_reg   <= ld_row[AW-1:0];
            c_reg   <= ld_col[AW-1:0];
            k_reg   <= '0;
            sum_reg <= 32'd0;
            oor_reg <= (pop_cmd.op == fmm_pkg::OP_REQ_OOR);
        end
        if (state_reg == S_MUL)
        begin
            mp_reg         <= m_prod;
            mexp_reg       <= m_exp;
            msign_reg      <= a_rd_reg[31] ^ b_rd_reg[31];
            mspec_reg      <= m_spec;
            mspec_bits_reg <= m_spec_bits;
        end
        if (state_reg == S_MRND)
        begin
            prod_reg <= mspec_reg ? mspec_bits_reg : mr_bits;
        end
        if (state_reg == S_ADD1)
        begin
            as_reg         <= a_sum;
            aexp_reg       <= a_ebig;
            asign_reg      <= a_big[31];
            azsign_reg     <= sum_reg[31] & prod_reg[31];
            aspec_reg      <= a_spec;
            aspec_bits_reg <= a_spec_bits;
        end
        if (state_reg == S_ADD2)
        begin
            sum_reg <= ar_bits;
            k_reg   <= SW'(k_reg + 1'b1);
        end
        if ((state_reg == S_OUT) && out_free)
        begin
            out_bits_reg <= oor_reg ? 32'd0 : sum_reg;
            out_oor_reg  <= oor_reg;
        end
    end

endmodule

>>> bench/testbench.sv
module testbench;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam logic [31:0] QUIET_BIT = 32'h0040_0000;
    localparam logic [31:0] DEFAULT_NAN = 32'hFFC0_0000;
    localparam int DIM = 64;
    localparam int DRAIN_CYCLES = 5 * DIM + 16;

    typedef struct {
        logic [31:0] bits;
        logic        oor;
    } c_elem_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  kind;
    logic [5:0]  row;
    logic [5:0]  col;
    logic [31:0] value_bits;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] product_bits;
    logic        out_of_range;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [6:0]  cfg_data;

    logic [31:0] a_mem [DIM*DIM];
    logic [31:0] b_mem [DIM*DIM];
    bit          a_set [DIM*DIM];
    bit          b_set [DIM*DIM];
    logic [6:0]  rows_reg;
    logic [6:0]  inner_reg;
    logic [6:0]  cols_reg;

    c_elem_t     pending_products [$];
    int          fail_count;
    int          items_sent;
    bit          no_idle;

    float_matrix_multiply_core #(
        .MAX_DIM(DIM)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .kind(kind),
        .row(row),
        .col(col),
        .value_bits(value_bits),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .product_bits(product_bits),
        .out_of_range(out_of_range),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic bit fp_is_nan(input logic [31:0] x);
        return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
    endfunction

    function automatic bit fp_is_inf(input logic [31:0] x);
        return (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
    endfunction

    function automatic void fp_unpack(input logic [31:0] x, output int e, output logic [23:0] m);
        if (x[30:23] == 8'd0)
        begin
            e = -126;
            m = {1'b0, x[22:0]};
        end
        else
        begin
            e = int'(x[30:23]) - 127;
            m = {1'b1, x[22:0]};
        end
    endfunction

    // The significand has its leading one at bit 63 and weighs 2**e there.
    function automatic logic [31:0] fp_round_pack(input logic s, input int e,
                                                  input logic [63:0] sig);
        int          be;
        int          sh;
        logic        sticky;
        logic [63:0] t;
        logic [31:0] res;
        be = e + 127;
        if (be >= 255)
            return {s, 8'hFF, 23'd0};
        if (be < 1)
        begin
            sh = 1 - be;
            if (sh > 63)
            begin
                t = 64'd0;
                t[0] = |sig;
            end
            else
            begin
                sticky = |(sig & ((64'd1 << sh) - 64'd1));
                t = sig >> sh;
                t[0] = t[0] | sticky;
            end
            sig = t;
            be = 1;
        end
        res = 32'(be - 1) << 23;
        res = res + {8'd0, sig[63:40]};
        if (sig[39] && ((|sig[38:0]) || sig[40]))
            res = res + 32'd1;
        return {s, res[30:0]};
    endfunction

    function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
        logic        s;
        int          ea;
        int          eb;
        int          e;
        logic [23:0] ma;
        logic [23:0] mb;
        logic [63:0] sig;
        if (fp_is_nan(a))
            return a | QUIET_BIT;
        if (fp_is_nan(b))
            return b | QUIET_BIT;
        s = a[31] ^ b[31];
        if (fp_is_inf(a) || fp_is_inf(b))
        begin
            if (a[30:0] == 31'd0 || b[30:0] == 31'd0)
                return DEFAULT_NAN;
            return {s, 8'hFF, 23'd0};
        end
        if (a[30:0] == 31'd0 || b[30:0] == 31'd0)
            return {s, 31'd0};
        fp_unpack(a, ea, ma);
        fp_unpack(b, eb, mb);
        sig = 64'(ma) * 64'(mb);
        e = ea + eb + 17;
        while (!sig[63])
        begin
            sig = sig << 1;
            e = e - 1;
        end
        return fp_round_pack(s, e, sig);
    endfunction

    function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
        int          ea;
        int          eb;
        int          d;
        int          e;
        logic [23:0] ma;
        logic [23:0] mb;
        logic [63:0] x;
        logic [63:0] y;
        logic [63:0] t;
        logic        sx;
        logic        sy;
        logic        st;
        if (fp_is_nan(a))
            return a | QUIET_BIT;
        if (fp_is_nan(b))
            return b | QUIET_BIT;
        if (fp_is_inf(a))
        begin
            if (fp_is_inf(b) && a[31] != b[31])
                return DEFAULT_NAN;
            return a;
        end
        if (fp_is_inf(b))
            return b;
        if (a[30:0] == 31'd0 && b[30:0] == 31'd0)
            return {a[31] & b[31], 31'd0};
        if (a[30:0] == 31'd0)
            return b;
        if (b[30:0] == 31'd0)
            return a;
        fp_unpack(a, ea, ma);
        fp_unpack(b, eb, mb);
        sx = a[31];
        sy = b[31];
        if (eb > ea || (eb == ea && mb > ma))
        begin
            d = ea;
            ea = eb;
            eb = d;
            {ma, mb} = {mb, ma};
            {sx, sy} = {sy, sx};
        end
        x = {1'b0, ma, 39'd0};
        y = {1'b0, mb, 39'd0};
        d = ea - eb;
        if (d > 63)
        begin
            t = 64'd0;
            t[0] = |y;
        end
        else
        begin
            st = |(y & ((64'd1 << d) - 64'd1));
            t = y >> d;
            t[0] = t[0] | st;
        end
        x = (sx == sy) ? x + t : x - t;
        if (x == 64'd0)
            return 32'd0;
        e = ea + 1;
        while (!x[63])
        begin
            x = x << 1;
            e = e - 1;
        end
        return fp_round_pack(sx, e, x);
    endfunction

    function automatic int eff_size(input logic [6:0] v);
        return (int'(v) > DIM) ? DIM : int'(v);
    endfunction

    function automatic logic [31:0] dot_row_col(input int r, input int c);
        logic [31:0] acc;
        int          n;
        n = eff_size(inner_reg);
        acc = 32'd0;
        for (int k = 0; k < n; k++)
            acc = fp_add(acc, fp_mul(a_mem[r*DIM+k], b_mem[k*DIM+c]));
        return acc;
    endfunction

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 5))
            0, 1:    return $urandom;
            2:       return {$urandom_range(0, 1) == 1, 8'($urandom_range(0, 1) ? 8'hFF : 8'h00),
                             23'($urandom_range(0, 3) == 0 ? 0 : $urandom)};
            default: return {$urandom_range(0, 1) == 1, 8'($urandom_range(118, 136)),
                             23'($urandom)};
        endcase
    endfunction

    function automatic void apply_item(input logic [1:0] k, input int r, input int c,
                                       input logic [31:0] v);
        int      m;
        int      n;
        int      p;
        c_elem_t res;
        m = eff_size(rows_reg);
        n = eff_size(inner_reg);
        p = eff_size(cols_reg);
        if (k == fmm_pkg::KIND_LOAD_A && r < m && c < n)
        begin
            a_mem[r*DIM+c] = v;
            a_set[r*DIM+c] = 1'b1;
        end
        else if (k == fmm_pkg::KIND_LOAD_B && r < n && c < p)
        begin
            b_mem[r*DIM+c] = v;
            b_set[r*DIM+c] = 1'b1;
        end
        else if (k == fmm_pkg::KIND_REQ)
        begin
            if (r >= m || c >= p)
            begin
                res.bits = 32'd0;
                res.oor = 1'b1;
            end
            else
            begin
                res.bits = dot_row_col(r, c);
                res.oor = 1'b0;
            end
            pending_products.push_back(res);
        end
    endfunction

    task automatic send_item(input logic [1:0] k, input int r, input int c,
                             input logic [31:0] v);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid = 1'b1;
        kind = k;
        row = 6'(r);
        col = 6'(c);
        value_bits = v;
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
        apply_item(k, r, c, v);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid = 1'b0;
        wait (pending_products.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [6:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            fmm_pkg::CFG_ROWS_M:  rows_reg = data;
            fmm_pkg::CFG_INNER_N: inner_reg = data;
            default:              cols_reg = data;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_sizes(input logic [6:0] m, input logic [6:0] n, input logic [6:0] p);
        wait_idle();
        write_reg(fmm_pkg::CFG_ROWS_M, m);
        write_reg(fmm_pkg::CFG_INNER_N, n);
        write_reg(fmm_pkg::CFG_COLS_P, p);
    endtask

    // Loads whatever the dot product still lacks, then asks for the element.
    task automatic request_element(input int r, input int c);
        int n;
        n = eff_size(inner_reg);
        if (r < eff_size(rows_reg) && c < eff_size(cols_reg))
        begin
            for (int k = 0; k < n; k++)
            begin
                if (!a_set[r*DIM+k])
                    send_item(fmm_pkg::KIND_LOAD_A, r, k, rand_value());
                if (!b_set[k*DIM+c])
                    send_item(fmm_pkg::KIND_LOAD_B, k, c, rand_value());
            end
        end
        send_item(fmm_pkg::KIND_REQ, r, c, $urandom);
    endtask

    task automatic test_directed();
        set_sizes(7'd2, 7'd2, 7'd2);
        send_item(fmm_pkg::KIND_LOAD_A, 0, 0, 32'h7F7F_FFFF);
        send_item(fmm_pkg::KIND_LOAD_A, 0, 1, 32'h7F7F_FFFF);
        send_item(fmm_pkg::KIND_LOAD_B, 0, 0, 32'h4000_0000);
        send_item(fmm_pkg::KIND_LOAD_B, 1, 0, 32'hFF7F_FFFF);
        send_item(fmm_pkg::KIND_REQ, 0, 0, 32'hFFFF_FFFF);
        send_item(fmm_pkg::KIND_LOAD_A, 1, 0, 32'h0000_0001);
        send_item(fmm_pkg::KIND_LOAD_A, 1, 1, 32'h8000_0001);
        send_item(fmm_pkg::KIND_LOAD_B, 0, 1, 32'h3F00_0000);
        send_item(fmm_pkg::KIND_LOAD_B, 1, 1, 32'h7FC0_0001);
        send_item(fmm_pkg::KIND_REQ, 1, 1, 32'd0);
        send_item(fmm_pkg::KIND_REQ, 1, 0, 32'd0);
        send_item(fmm_pkg::KIND_REQ, 0, 1, 32'd0);
        send_item(fmm_pkg::KIND_LOAD_B, 1, 1, 32'h8000_0000);
        send_item(fmm_pkg::KIND_REQ, 1, 1, 32'd0);
        send_item(fmm_pkg::KIND_LOAD_A, 2, 0, 32'h3F80_0000);
        send_item(fmm_pkg::KIND_LOAD_B, 0, 2, 32'h3F80_0000);
        send_item(fmm_pkg::KIND_LOAD_A, 63, 63, 32'h3F80_0000);
        send_item(KIND_UNUSED, 0, 0, 32'h3F80_0000);
        send_item(fmm_pkg::KIND_REQ, 2, 0, 32'd0);
        send_item(fmm_pkg::KIND_REQ, 0, 63, 32'd0);
        send_item(fmm_pkg::KIND_REQ, 63, 63, 32'd0);
        send_item(fmm_pkg::KIND_REQ, 0, 0, 32'd0);
    endtask

    task automatic test_size_extremes();
        set_sizes(7'd0, 7'd0, 7'd0);
        send_item(fmm_pkg::KIND_LOAD_A, 0, 0, 32'h3F80_0000);
        send_item(fmm_pkg::KIND_LOAD_B, 0, 0, 32'h3F80_0000);
        send_item(fmm_pkg::KIND_REQ, 0, 0, 32'd0);
        set_sizes(7'd1, 7'd0, 7'd1);
        send_item(fmm_pkg::KIND_REQ, 0, 0, 32'd0);
        send_item(fmm_pkg::KIND_REQ, 1, 0, 32'd0);
        set_sizes(7'd127, 7'd127, 7'd127);
        request_element(63, 63);
        request_element(0, 0);
        set_sizes(7'd64, 7'd64, 7'd64);
        request_element(63, 0);
        request_element(5, 63);
        set_sizes(7'd64, 7'd1, 7'd1);
        request_element(63, 0);
        send_item(fmm_pkg::KIND_REQ, 0, 1, 32'd0);
    endtask

    task automatic test_pause_for_results();
        set_sizes(7'd3, 7'd4, 7'd3);
        for (int i = 0; i < 6; i++)
            request_element($urandom_range(0, 2), $urandom_range(0, 2));
        @(negedge clk);
        in_valid = 1'b0;
        wait (pending_products.size() == 0);
        for (int i = 0; i < 6; i++)
            request_element($urandom_range(0, 2), $urandom_range(0, 2));
    endtask

    function automatic logic [6:0] rand_size();
        if ($urandom_range(0, 11) == 0)
            return 7'($urandom_range(0, 1) ? $urandom_range(9, 127) : 0);
        return 7'($urandom_range(1, 8));
    endfunction

    task automatic test_random_traffic();
        int m;
        int n;
        int p;
        int sel;
        while (items_sent < 1550)
        begin
            set_sizes(rand_size(), rand_size(), rand_size());
            m = eff_size(rows_reg);
            n = eff_size(inner_reg);
            p = eff_size(cols_reg);
            no_idle = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < 60 && items_sent < 1550; i++)
            begin
                sel = $urandom_range(0, 99);
                if (sel < 55 && m > 0 && p > 0)
                    request_element($urandom_range(0, m - 1), $urandom_range(0, p - 1));
                else if (sel < 70 && m > 0 && n > 0)
                    send_item(fmm_pkg::KIND_LOAD_A, $urandom_range(0, m - 1),
                              $urandom_range(0, n - 1), rand_value());
                else if (sel < 80 && n > 0 && p > 0)
                    send_item(fmm_pkg::KIND_LOAD_B, $urandom_range(0, n - 1),
                              $urandom_range(0, p - 1), rand_value());
                else if (sel < 88)
                    send_item($urandom_range(0, 1) ? fmm_pkg::KIND_LOAD_B : fmm_pkg::KIND_LOAD_A,
                              $urandom_range(0, 63), $urandom_range(0, 63), $urandom);
                else if (sel < 95 && m < DIM)
                    send_item(fmm_pkg::KIND_REQ, $urandom_range(m, 63), $urandom_range(0, 63),
                              $urandom);
                else
                    send_item(KIND_UNUSED, $urandom_range(0, 63), $urandom_range(0, 63),
                              $urandom);
            end
            no_idle = 1'b0;
        end
    endtask

    initial
    begin
        int w;
        out_stall = 1'b0;
        forever
        begin
            w = no_idle ? 0 : $urandom_range(0, 3);
            if (w > 0)
            begin
                @(negedge clk);
                out_stall = 1'b1;
                repeat (w - 1) @(negedge clk);
                @(negedge clk);
                out_stall = 1'b0;
            end
            do
                @(posedge clk);
            while (!(rst_n && out_valid && !out_stall));
        end
    end

    always @(posedge clk)
    begin
        c_elem_t exp_elem;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_products.size() == 0)
            begin
                $error("unexpected result: product_bits %h out_of_range %b",
                       product_bits, out_of_range);
                fail_count++;
            end
            else
            begin
                exp_elem = pending_products.pop_front();
                if (product_bits !== exp_elem.bits)
                begin
                    $error("product_bits: expected %h, actual %h", exp_elem.bits, product_bits);
                    fail_count++;
                end
                if (out_of_range !== exp_elem.oor)
                begin
                    $error("out_of_range: expected %b, actual %b", exp_elem.oor, out_of_range);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        #20000000;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        kind = fmm_pkg::KIND_LOAD_A;
        row = 6'd0;
        col = 6'd0;
        value_bits = 32'd0;
        cfg_valid = 1'b0;
        cfg_index = fmm_pkg::CFG_ROWS_M;
        cfg_data = 7'd0;
        rows_reg = 7'd64;
        inner_reg = 7'd64;
        cols_reg = 7'd64;
        fail_count = 0;
        items_sent = 0;
        no_idle = 1'b0;
        for (int i = 0; i < DIM*DIM; i++)
        begin
            a_set[i] = 1'b0;
            b_set[i] = 1'b0;
            a_mem[i] = 32'd0;
            b_mem[i] = 32'd0;
        end
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_size_extremes();
        test_pause_for_results();
        test_random_traffic();

        @(negedge clk);
        in_valid = 1'b0;
        wait (pending_products.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> float_matrix_multiply_core.f
src/fmm_pkg.sv
src/fmm_front.sv
src/fmm_queue.sv
src/fmm_back.sv
src/float_matrix_multiply_core.sv
bench/testbench.sv
